### rtl/core/cubic_hermite_spline_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Hermite spline table
// Short forms of the concurrent assertions that the checker writes.
// ----------------------------------------------------------------------------
`ifndef CUBIC_HERMITE_SPLINE_TABLE_MACROS_SVH
`define CUBIC_HERMITE_SPLINE_TABLE_MACROS_SVH

// A property checked on each rising edge and held off while reset is low.
`define CHST_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// The same check on the clock and reset named clk and arst_n.
`define CHST_ASSERT(lbl, prop, msg) `CHST_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### rtl/core/chst_pkg.sv
// ----------------------------------------------------------------------------
// chst_pkg
// Types, constants and saturation helpers of the cubic Hermite spline table.
// ----------------------------------------------------------------------------
package chst_pkg;

	// Table geometry and number formats.
	localparam int MAX_POINTS  = 64;
	localparam int COORD_WIDTH = 32;
	localparam int ADDR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int T_W         = (17 + CNT_W > 24) ? 17 + CNT_W : 24;
	localparam int WIDE_W      = 96;

	localparam logic signed [WIDE_W-1:0] COORD_HI = (WIDE_W'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam logic signed [WIDE_W-1:0] COORD_LO = -COORD_HI - 1;
	localparam logic signed [WIDE_W-1:0] OUT_HI   = (WIDE_W'(1) <<< 31) - 1;
	localparam logic signed [WIDE_W-1:0] OUT_LO   = -OUT_HI - 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	// Command codes as they arrive on the mode field.
	typedef enum logic [3:0] {
		MODE_INSERT   = 4'd0,
		MODE_REMOVE   = 4'd1,
		MODE_SET_PT   = 4'd2,
		MODE_SET_POS  = 4'd3,
		MODE_SET_VEL  = 4'd4,
		MODE_CLEAR    = 4'd5,
		MODE_CARDINAL = 4'd6,
		MODE_EVAL_CUM = 4'd7,
		MODE_EVAL_NRM = 4'd8,
		MODE_READ     = 4'd9
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FEW   = 2'd3
	} status_t;

	// Operation classes after decoding.
	typedef enum logic [2:0] {
		OPC_NOP    = 3'd0,
		OPC_INSERT = 3'd1,
		OPC_REMOVE = 3'd2,
		OPC_SET    = 3'd3,
		OPC_CLEAR  = 3'd4,
		OPC_CARD   = 3'd5,
		OPC_EVAL   = 3'd6,
		OPC_READ   = 3'd7
	} opc_t;

	// One command transaction as it arrives.
	typedef struct packed {
		logic [3:0]         mode;
		logic [6:0]         index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] end_vel_x;
		logic signed [31:0] end_vel_y;
		logic [23:0]        param_t;
		logic [16:0]        tension;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic [6:0]         point_count;
		logic [1:0]         status;
	} result_t;

	// Decoded command handed from the front end to the back end.
	typedef struct packed {
		opc_t        op;
		logic        set_pos;
		logic        set_vel;
		logic        norm;
		logic [6:0]  index;
		coord_t      px;
		coord_t      py;
		coord_t      vx;
		coord_t      vy;
		coord_t      ex;
		coord_t      ey;
		logic [23:0] t;
		logic [16:0] tension;
	} cmd_t;

	// One table entry.
	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t vx;
		coord_t vy;
	} point_t;

	// Saturate a wide signed value into the stored coordinate width.
	function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
		coord_t r;
		if (v > COORD_HI) begin
			r = COORD_HI[COORD_WIDTH-1:0];
		end else if (v < COORD_LO) begin
			r = COORD_LO[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	// Bring a 32-bit input into the stored coordinate width.
	function automatic coord_t in_coord(input logic signed [31:0] raw);
		logic signed [WIDE_W-1:0] w;
		w = WIDE_W'(raw);
		return sat_coord(w);
	endfunction

	// Saturate a stored coordinate to the 32-bit result field.
	function automatic logic signed [31:0] sat_out(input coord_t c);
		logic signed [WIDE_W-1:0] w;
		logic signed [31:0]       r;
		w = WIDE_W'(c);
		if (w > OUT_HI) begin
			r = OUT_HI[31:0];
		end else if (w < OUT_LO) begin
			r = OUT_LO[31:0];
		end else begin
			r = w[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/chst_front.sv
// ----------------------------------------------------------------------------
// chst_front
// Accepts command transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module chst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  chst_pkg::in_item_t command,
	input  logic              push,
	output logic              full,
	output chst_pkg::cmd_t    head,
	output logic              head_valid,
	input  logic              head_pop
);
	import chst_pkg::*;

	cmd_t       dec;
	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	// Decode the mode into an operation class and condition the operands.
	always_comb begin
		dec         = '0;
		dec.op      = OPC_NOP;
		dec.index   = command.index;
		dec.px      = in_coord(command.pos_x);
		dec.py      = in_coord(command.pos_y);
		dec.vx      = in_coord(command.vel_x);
		dec.vy      = in_coord(command.vel_y);
		dec.ex      = in_coord(command.end_vel_x);
		dec.ey      = in_coord(command.end_vel_y);
		dec.t       = command.param_t;
		dec.tension = command.tension;
		unique case (command.mode) inside
			MODE_INSERT: begin
				dec.op = OPC_INSERT;
			end
			MODE_REMOVE: begin
				dec.op = OPC_REMOVE;
			end
			MODE_SET_PT, MODE_SET_POS, MODE_SET_VEL: begin
				dec.op      = OPC_SET;
				dec.set_pos = (command.mode != MODE_SET_VEL);
				dec.set_vel = (command.mode != MODE_SET_POS);
			end
			MODE_CLEAR: begin
				dec.op = OPC_CLEAR;
			end
			MODE_CARDINAL: begin
				dec.op = OPC_CARD;
			end
			MODE_EVAL_CUM, MODE_EVAL_NRM: begin
				dec.op   = OPC_EVAL;
				dec.norm = (command.mode == MODE_EVAL_NRM);
			end
			MODE_READ: begin
				dec.op = OPC_READ;
			end
			default: begin
				dec.op = OPC_NOP;
			end
		endcase
	end

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head       = q_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q] <= dec;
		end
	end

endmodule

### rtl/core/chst_back.sv
// ----------------------------------------------------------------------------
// chst_back
// Executes decoded commands on the point table and returns one result each.
// ----------------------------------------------------------------------------
module chst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  chst_pkg::cmd_t   head,
	input  logic             head_valid,
	output logic             head_pop,
	output chst_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);
	import chst_pkg::*;

	localparam int CMP_W  = 32;
	localparam int KPROD_W = 18 + COORD_WIDTH + 1;
	localparam int HPROD_W = 32 + COORD_WIDTH;
	localparam int ACC_W   = HPROD_W + 2;
	localparam logic signed [WIDE_W-1:0] RND17 = WIDE_W'(1) <<< 16;
	localparam logic signed [WIDE_W-1:0] RND30 = WIDE_W'(1) <<< 29;

	typedef enum logic [20:0] {
		S_IDLE    = 21'd1 << 0,
		S_INS_RD  = 21'd1 << 1,
		S_INS_WR  = 21'd1 << 2,
		S_INS_PUT = 21'd1 << 3,
		S_REM_RD  = 21'd1 << 4,
		S_REM_WR  = 21'd1 << 5,
		S_SET_WR  = 21'd1 << 6,
		S_RD_WAIT = 21'd1 << 7,
		S_CRD_I0  = 21'd1 << 8,
		S_CRD_I1  = 21'd1 << 9,
		S_CRD_I2  = 21'd1 << 10,
		S_CRD_MUL = 21'd1 << 11,
		S_CRD_WR  = 21'd1 << 12,
		S_EV_T    = 21'd1 << 13,
		S_EV_SEG  = 21'd1 << 14,
		S_EV_U2   = 21'd1 << 15,
		S_EV_U3   = 21'd1 << 16,
		S_EV_H    = 21'd1 << 17,
		S_EV_MAC  = 21'd1 << 18,
		S_EV_OUT  = 21'd1 << 19,
		S_RESP    = 21'd1 << 20
	} state_t;

	state_t  state_q, state_d;
	cnt_t    count_q, count_d;
	logic    out_valid_q;
	logic    load_out;
	result_t out_q;

	cmd_t    cmd_q;
	cnt_t    i_q;
	status_t disp_st;
	status_t res_st_q;
	logic signed [31:0] res_x_q, res_y_q, res_vx_q, res_vy_q;

	// Point memory, one write and one registered read per cycle.
	point_t  mem [MAX_POINTS];
	point_t  rd_data_q;
	logic    mem_re, mem_we;
	addr_t   mem_raddr, mem_waddr;
	point_t  mem_wdata;

	// Cardinal window and multiply stage.
	point_t  cur_q, next_q;
	coord_t  prev_x_q, prev_y_q;
	logic signed [KPROD_W-1:0] kprod_x_s1, kprod_y_s1;
	logic signed [17:0]        kten;
	logic signed [COORD_WIDTH:0] diff_x, diff_y;
	coord_t  card_vx, card_vy;

	// Evaluation datapath.
	logic [T_W-1:0]  t_q;
	logic [T_W-1:0]  t_norm;
	logic [16:0]     t_min;
	logic [16:0]     u_q, u_c;
	logic [33:0]     u2_q;
	logic [50:0]     u3_q;
	addr_t           seg_q, seg_c;
	logic            seg_past;
	logic signed [53:0] u1e, u2e, u3e, qv0, qv1, qv2, qv3;
	logic signed [31:0] h_q [4];
	logic signed [31:0] hn  [4];
	point_t          e0_q, e1_q;
	logic [2:0]      k_q;
	coord_t          xsel, ysel;
	logic signed [HPROD_W-1:0] mac_x_s1, mac_y_s1;
	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
	logic signed [WIDE_W-1:0]  wide_x, wide_y;

	logic [CMP_W-1:0] hidx_w, cnt_w, i_w;

	assign hidx_w = CMP_W'(head.index);
	assign cnt_w  = CMP_W'(count_q);
	assign i_w    = CMP_W'(i_q);

	// Status of the command at the head of the queue, against the current count.
	always_comb begin
		disp_st = ST_OK;
		unique case (head.op) inside
			OPC_INSERT: begin
				if (count_q == CNT_W'(MAX_POINTS)) begin
					disp_st = ST_FULL;
				end else if (hidx_w > cnt_w) begin
					disp_st = ST_RANGE;
				end
			end
			OPC_REMOVE, OPC_SET, OPC_READ: begin
				if (hidx_w >= cnt_w) begin
					disp_st = ST_RANGE;
				end
			end
			OPC_EVAL: begin
				if (cnt_w < CMP_W'(2)) begin
					disp_st = ST_FEW;
				end
			end
			default: begin
				disp_st = ST_OK;
			end
		endcase
	end

	// Cardinal velocity of the current point from its neighbors.
	assign kten    = 18'sd65536 - $signed({1'b0, cmd_q.tension});
	assign diff_x  = (COORD_WIDTH+1)'(next_q.px) - (COORD_WIDTH+1)'(prev_x_q);
	assign diff_y  = (COORD_WIDTH+1)'(next_q.py) - (COORD_WIDTH+1)'(prev_y_q);
	assign card_vx = sat_coord((WIDE_W'(kprod_x_s1) + RND17) >>> 17);
	assign card_vy = sat_coord((WIDE_W'(kprod_y_s1) + RND17) >>> 17);

	// Segment and local parameter, clamped to the end of the last segment.
	assign t_min    = (cmd_q.t > 24'd65536) ? 17'd65536 : cmd_q.t[16:0];
	assign t_norm   = T_W'(t_min) * T_W'(count_q - CNT_W'(1));
	assign seg_past = CMP_W'(t_q[T_W-1:16]) >= CMP_W'(count_q - CNT_W'(1));
	assign seg_c    = seg_past ? ADDR_W'(count_q - CNT_W'(2)) : ADDR_W'(t_q[T_W-1:16]);
	assign u_c      = seg_past ? 17'd65536 : {1'b0, t_q[15:0]};

	// Hermite basis values in Q30, rounded half up.
	always_comb begin
		u1e = 54'(u_q);
		u2e = 54'(u2_q);
		u3e = 54'(u3_q);
		qv0 = (u3e <<< 1) - ((u2e <<< 17) + (u2e <<< 16)) + (54'sd1 <<< 48);
		qv1 = u3e - (u2e <<< 17) + (u1e <<< 32);
		qv2 = (u2e <<< 17) + (u2e <<< 16) - (u3e <<< 1);
		qv3 = u3e - (u2e <<< 16);
		hn[0] = 32'((qv0 + (54'sd1 <<< 17)) >>> 18);
		hn[1] = 32'((qv1 + (54'sd1 <<< 17)) >>> 18);
		hn[2] = 32'((qv2 + (54'sd1 <<< 17)) >>> 18);
		hn[3] = 32'((qv3 + (54'sd1 <<< 17)) >>> 18);
	end

	// Operand of the current weighted-sum term.
	always_comb begin
		case (k_q[1:0])
			2'd0: begin
				xsel = e0_q.px;
				ysel = e0_q.py;
			end
			2'd1: begin
				xsel = e0_q.vx;
				ysel = e0_q.vy;
			end
			2'd2: begin
				xsel = e1_q.px;
				ysel = e1_q.py;
			end
			default: begin
				xsel = e1_q.vx;
				ysel = e1_q.vy;
			end
		endcase
	end

	assign wide_x = WIDE_W'(acc_x_q);
	assign wide_y = WIDE_W'(acc_y_q);

	// Sequencer: next state, count update and memory port control.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		head_pop  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_data_q;
		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					head_pop = 1'b1;
					if (disp_st != ST_OK) begin
						state_d = S_RESP;
					end else begin
						unique case (head.op)
							OPC_INSERT: begin
								state_d = (cnt_w > hidx_w) ? S_INS_RD : S_INS_PUT;
							end
							OPC_REMOVE: begin
								if (hidx_w + CMP_W'(1) < cnt_w) begin
									state_d = S_REM_RD;
								end else begin
									count_d = count_q - CNT_W'(1);
									state_d = S_RESP;
								end
							end
							OPC_SET: begin
								mem_re    = 1'b1;
								mem_raddr = ADDR_W'(head.index);
								state_d   = S_SET_WR;
							end
							OPC_CLEAR: begin
								count_d = '0;
								state_d = S_RESP;
							end
							OPC_CARD: begin
								state_d = (count_q == '0) ? S_RESP : S_CRD_I0;
							end
							OPC_EVAL: begin
								state_d = S_EV_T;
							end
							OPC_READ: begin
								mem_re    = 1'b1;
								mem_raddr = ADDR_W'(head.index);
								state_d   = S_RD_WAIT;
							end
							default: begin
								state_d = S_RESP;
							end
						endcase
					end
				end
			end
			S_INS_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(i_q - CNT_W'(1));
				state_d   = S_INS_WR;
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(i_q);
				state_d   = (i_w - CMP_W'(1) > CMP_W'(cmd_q.index)) ? S_INS_RD : S_INS_PUT;
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cmd_q.index);
				mem_wdata = '{px: cmd_q.px, py: cmd_q.py, vx: cmd_q.vx, vy: cmd_q.vy};
				count_d   = count_q + CNT_W'(1);
				state_d   = S_RESP;
			end
			S_REM_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(i_q + CNT_W'(1));
				state_d   = S_REM_WR;
			end
			S_REM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(i_q);
				if (i_w + CMP_W'(2) < cnt_w) begin
					state_d = S_REM_RD;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = S_RESP;
				end
			end
			S_SET_WR: begin
				mem_we       = 1'b1;
				mem_waddr    = ADDR_W'(cmd_q.index);
				mem_wdata.px = cmd_q.set_pos ? cmd_q.px : rd_data_q.px;
				mem_wdata.py = cmd_q.set_pos ? cmd_q.py : rd_data_q.py;
				mem_wdata.vx = cmd_q.set_vel ? cmd_q.vx : rd_data_q.vx;
				mem_wdata.vy = cmd_q.set_vel ? cmd_q.vy : rd_data_q.vy;
				state_d      = S_RESP;
			end
			S_RD_WAIT: begin
				state_d = S_RESP;
			end
			S_CRD_I0: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
				state_d   = S_CRD_I1;
			end
			S_CRD_I1: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(1);
				state_d   = S_CRD_I2;
			end
			S_CRD_I2: begin
				state_d = S_CRD_MUL;
			end
			S_CRD_MUL: begin
				if (i_w + CMP_W'(2) < cnt_w) begin
					mem_re    = 1'b1;
					mem_raddr = ADDR_W'(i_q + CNT_W'(2));
				end
				state_d = S_CRD_WR;
			end
			S_CRD_WR: begin
				mem_we       = 1'b1;
				mem_waddr    = ADDR_W'(i_q);
				mem_wdata.px = cur_q.px;
				mem_wdata.py = cur_q.py;
				if (i_q == '0) begin
					mem_wdata.vx = cmd_q.vx;
					mem_wdata.vy = cmd_q.vy;
				end else if (i_w + CMP_W'(1) == cnt_w) begin
					mem_wdata.vx = cmd_q.ex;
					mem_wdata.vy = cmd_q.ey;
				end else begin
					mem_wdata.vx = card_vx;
					mem_wdata.vy = card_vy;
				end
				state_d = (i_w + CMP_W'(1) == cnt_w) ? S_RESP : S_CRD_MUL;
			end
			S_EV_T: begin
				state_d = S_EV_SEG;
			end
			S_EV_SEG: begin
				mem_re    = 1'b1;
				mem_raddr = seg_c;
				state_d   = S_EV_U2;
			end
			S_EV_U2: begin
				mem_re    = 1'b1;
				mem_raddr = seg_q + ADDR_W'(1);
				state_d   = S_EV_U3;
			end
			S_EV_U3: begin
				state_d = S_EV_H;
			end
			S_EV_H: begin
				state_d = S_EV_MAC;
			end
			S_EV_MAC: begin
				if (k_q == 3'd4) begin
					state_d = S_EV_OUT;
				end
			end
			S_EV_OUT: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || pop) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load_out = (state_q == S_RESP) && (!out_valid_q || pop);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Point memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q    <= head;
				res_st_q <= disp_st;
				res_x_q  <= '0;
				res_y_q  <= '0;
				res_vx_q <= '0;
				res_vy_q <= '0;
				if (head.op == OPC_INSERT) begin
					i_q <= count_q;
				end else if (head.op == OPC_REMOVE) begin
					i_q <= CNT_W'(head.index);
				end else begin
					i_q <= '0;
				end
			end
			S_INS_WR: begin
				i_q <= i_q - CNT_W'(1);
			end
			S_REM_WR: begin
				i_q <= i_q + CNT_W'(1);
			end
			S_RD_WAIT: begin
				res_x_q  <= sat_out(rd_data_q.px);
				res_y_q  <= sat_out(rd_data_q.py);
				res_vx_q <= sat_out(rd_data_q.vx);
				res_vy_q <= sat_out(rd_data_q.vy);
			end
			S_CRD_I1: begin
				cur_q <= rd_data_q;
			end
			S_CRD_I2: begin
				next_q <= rd_data_q;
			end
			S_CRD_MUL: begin
				kprod_x_s1 <= kten * diff_x;
				kprod_y_s1 <= kten * diff_y;
			end
			S_CRD_WR: begin
				prev_x_q <= cur_q.px;
				prev_y_q <= cur_q.py;
				cur_q    <= next_q;
				next_q   <= rd_data_q;
				i_q      <= i_q + CNT_W'(1);
			end
			S_EV_T: begin
				t_q <= cmd_q.norm ? t_norm : T_W'(cmd_q.t);
			end
			S_EV_SEG: begin
				seg_q <= seg_c;
				u_q   <= u_c;
			end
			S_EV_U2: begin
				u2_q <= 34'(u_q) * 34'(u_q);
				e0_q <= rd_data_q;
			end
			S_EV_U3: begin
				u3_q <= 51'(u2_q) * 51'(u_q);
				e1_q <= rd_data_q;
			end
			S_EV_H: begin
				h_q[0]  <= hn[0];
				h_q[1]  <= hn[1];
				h_q[2]  <= hn[2];
				h_q[3]  <= hn[3];
				k_q     <= '0;
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
			S_EV_MAC: begin
				mac_x_s1 <= h_q[k_q[1:0]] * xsel;
				mac_y_s1 <= h_q[k_q[1:0]] * ysel;
				if (k_q != 3'd0) begin
					acc_x_q <= acc_x_q + ACC_W'(mac_x_s1);
					acc_y_q <= acc_y_q + ACC_W'(mac_y_s1);
				end
				k_q <= k_q + 3'd1;
			end
			S_EV_OUT: begin
				res_x_q <= sat_out(sat_coord((wide_x + RND30) >>> 30));
				res_y_q <= sat_out(sat_coord((wide_y + RND30) >>> 30));
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_q.out_x       <= res_x_q;
			out_q.out_y       <= res_y_q;
			out_q.out_vel_x   <= res_vx_q;
			out_q.out_vel_y   <= res_vy_q;
			out_q.point_count <= 7'(count_q);
			out_q.status      <= res_st_q;
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

### rtl/core/cubic_hermite_spline_table.sv
// ----------------------------------------------------------------------------
// cubic_hermite_spline_table
// Table of 2D cubic Hermite control points with edit, cardinal and evaluate.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port: a transaction is taken on a
// rising edge with push high and full low. Results leave the same way: the
// oldest result is on result while empty is low and is taken when pop is
// high. Every command gives exactly one result.
// A two-entry command queue sits between the decoder and the executor, and
// a result register sits at the output, so a new command is accepted while
// a result still waits to be popped.
// In the executor, insert and remove take longer the more points they move, and
// cardinal takes longer the more points the table holds. The walk over the point
// memory, which reads and then writes one point at a time, sets the rate of
// insert, remove and cardinal.
// Reset clears the point count and both queues; the point memory is not
// cleared and is only read below the count, except that a cardinal on one
// point also reads unused entry 1. While result is not popped the executor
// holds its finished result and the command queue fills, then full rises.
module cubic_hermite_spline_table (
	input  logic               clk,
	input  logic               arst_n,
	input  chst_pkg::in_item_t command,
	input  logic               push,
	output logic               full,
	output chst_pkg::result_t  result,
	output logic               empty,
	input  logic               pop
);
	import chst_pkg::*;

	cmd_t head;
	logic head_valid;
	logic head_pop;

	// Decoder and command queue.
	chst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.push       (push),
		.full       (full),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	// Executor with point memory and result register.
	chst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

### rtl/core/chst_checker.sv
// ----------------------------------------------------------------------------
// chst_checker
// Port-level checks of the spline table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "cubic_hermite_spline_table_macros.svh"

module chst_checker (
	input logic              clk,
	input logic              arst_n,
	input chst_pkg::result_t result,
	input logic              empty,
	input logic              pop
);
	import chst_pkg::*;

	logic [6:0] last_cnt_q;
	logic       seen_q;
	logic       take;
	logic       cnt_step_ok;
	logic       err_zero_ok;

	assign take = pop && !empty;

	// Count of the previous result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (take) begin
			seen_q     <= 1'b1;
			last_cnt_q <= result.point_count;
		end
	end

	// One command moves the count by at most one, or clears it.
	assign cnt_step_ok = (result.point_count == last_cnt_q)
		|| (result.point_count == last_cnt_q + 7'd1)
		|| (result.point_count == last_cnt_q - 7'd1)
		|| (result.point_count == 7'd0);

	// A failed command returns no data.
	assign err_zero_ok = (result.out_x == '0) && (result.out_y == '0)
		&& (result.out_vel_x == '0) && (result.out_vel_y == '0);

	`CHST_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while stalled")
	`CHST_ASSERT(a_step, (take && seen_q) |-> cnt_step_ok, "point count jumped between results")
	`CHST_ASSERT(a_full, (!empty && (result.status == ST_FULL)) |-> (result.point_count == 7'(MAX_POINTS)), "full status below capacity")
	`CHST_ASSERT(a_err, (!empty && (result.status != ST_OK)) |-> (err_zero_ok && ((result.status != ST_FEW) || (result.point_count < 7'd2))), "error result carries data")

endmodule

bind cubic_hermite_spline_table chst_checker u_chk (.*);
